// ===== src/sip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sip_pkg;

	localparam int SIP_COORD_BITS = 11;
	localparam int SIP_FRAC_BITS  = 8;

	typedef struct packed {
		logic hit;
		logic neg_x;
		logic neg_y;
	} sip_flags_t;

endpackage

`default_nettype wire

// ===== src/sip_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sip_front #(
	parameter int COORD_BITS = sip_pkg::SIP_COORD_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [COORD_BITS-1:0]              p0x,
	input  wire logic [COORD_BITS-1:0]              p0y,
	input  wire logic [COORD_BITS-1:0]              p1x,
	input  wire logic [COORD_BITS-1:0]              p1y,
	input  wire logic [COORD_BITS-1:0]              p2x,
	input  wire logic [COORD_BITS-1:0]              p2y,
	input  wire logic [COORD_BITS-1:0]              p3x,
	input  wire logic [COORD_BITS-1:0]              p3y,
	output logic                                    dn_valid,
	input  wire logic                               dn_ready,
	output logic [3*COORD_BITS:0]                   q_x,
	output logic [3*COORD_BITS:0]                   q_y,
	output logic [2*COORD_BITS:0]                   den,
	output sip_pkg::sip_flags_t                     flags,
	output logic [COORD_BITS-1:0]                   base_x,
	output logic [COORD_BITS-1:0]                   base_y
);
	import sip_pkg::*;

	localparam int CW  = COORD_BITS;
	localparam int EW  = CW + 1;
	localparam int PW  = 2 * EW;
	localparam int SW  = PW + 1;
	localparam int DW  = 2 * CW + 1;
	localparam int QLW = DW + CW;

	logic signed [EW-1:0] s1x, s1y, s2x, s2y, dx, dy;
	logic signed [PW-1:0] ma, mb, mc, md, me, mf;

	logic                 v_s1;
	logic signed [PW-1:0] ma_s1, mb_s1, mc_s1, md_s1, me_s1, mf_s1;
	logic signed [EW-1:0] s1x_s1, s1y_s1;
	logic [CW-1:0]        p0x_s1, p0y_s1;

	logic signed [SW-1:0] d_raw, sn_raw, tn_raw, d_abs, sn_f, tn_f;
	logic signed [EW-1:0] ax, ay;
	logic                 hit_c;

	logic                 v_s2;
	logic [DW-1:0]        d_s2, tn_s2;
	sip_flags_t           flags_s2;
	logic [CW-1:0]        magx_s2, magy_s2, p0x_s2, p0y_s2;

	logic                 v_s3;
	logic [QLW-1:0]       qx_s3, qy_s3;
	logic [DW-1:0]        d_s3;
	sip_flags_t           flags_s3;
	logic [CW-1:0]        p0x_s3, p0y_s3;

	logic rdy1, rdy2, rdy3;

	assign rdy3     = !v_s3 || dn_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_comb begin
		s1x = $signed({1'b0, p1x}) - $signed({1'b0, p0x});
		s1y = $signed({1'b0, p1y}) - $signed({1'b0, p0y});
		s2x = $signed({1'b0, p3x}) - $signed({1'b0, p2x});
		s2y = $signed({1'b0, p3y}) - $signed({1'b0, p2y});
		dx  = $signed({1'b0, p0x}) - $signed({1'b0, p2x});
		dy  = $signed({1'b0, p0y}) - $signed({1'b0, p2y});
		ma  = s1x * s2y;
		mb  = s2x * s1y;
		mc  = s1x * dy;
		md  = s1y * dx;
		me  = s2x * dy;
		mf  = s2y * dx;
	end

	always_comb begin
		d_raw  = SW'(ma_s1) - SW'(mb_s1);
		sn_raw = SW'(mc_s1) - SW'(md_s1);
		tn_raw = SW'(me_s1) - SW'(mf_s1);
		if (d_raw[SW-1]) begin
			d_abs = -d_raw;
			sn_f  = -sn_raw;
			tn_f  = -tn_raw;
		end else begin
			d_abs = d_raw;
			sn_f  = sn_raw;
			tn_f  = tn_raw;
		end
		hit_c = (d_abs != '0) && !sn_f[SW-1] && (sn_f <= d_abs)
			&& !tn_f[SW-1] && (tn_f <= d_abs);
		ax = s1x_s1[EW-1] ? -s1x_s1 : s1x_s1;
		ay = s1y_s1[EW-1] ? -s1y_s1 : s1y_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			ma_s1  <= ma;
			mb_s1  <= mb;
			mc_s1  <= mc;
			md_s1  <= md;
			me_s1  <= me;
			mf_s1  <= mf;
			s1x_s1 <= s1x;
			s1y_s1 <= s1y;
			p0x_s1 <= p0x;
			p0y_s1 <= p0y;
		end
		if (rdy2) begin
			d_s2           <= d_abs[DW-1:0];
			tn_s2          <= tn_f[DW-1:0];
			flags_s2.hit   <= hit_c;
			flags_s2.neg_x <= s1x_s1[EW-1];
			flags_s2.neg_y <= s1y_s1[EW-1];
			magx_s2        <= ax[CW-1:0];
			magy_s2        <= ay[CW-1:0];
			p0x_s2         <= p0x_s1;
			p0y_s2         <= p0y_s1;
		end
		if (rdy3) begin
			qx_s3    <= QLW'(tn_s2) * QLW'(magx_s2);
			qy_s3    <= QLW'(tn_s2) * QLW'(magy_s2);
			d_s3     <= d_s2;
			flags_s3 <= flags_s2;
			p0x_s3   <= p0x_s2;
			p0y_s3   <= p0y_s2;
		end
	end

	assign dn_valid = v_s3;
	assign q_x      = qx_s3;
	assign q_y      = qy_s3;
	assign den      = d_s3;
	assign flags    = flags_s3;
	assign base_x   = p0x_s3;
	assign base_y   = p0y_s3;

endmodule

`default_nettype wire

// ===== src/sip_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sip_div_cell #(
	parameter int COORD_BITS = sip_pkg::SIP_COORD_BITS,
	parameter int FRAC_BITS  = sip_pkg::SIP_FRAC_BITS
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     up_valid,
	output logic                                          up_ready,
	input  wire logic [3*COORD_BITS+FRAC_BITS:0]          acc_x_in,
	input  wire logic [3*COORD_BITS+FRAC_BITS:0]          acc_y_in,
	input  wire logic [2*COORD_BITS:0]                    den_in,
	input  wire sip_pkg::sip_flags_t                      flags_in,
	input  wire logic [COORD_BITS-1:0]                    base_x_in,
	input  wire logic [COORD_BITS-1:0]                    base_y_in,
	output logic                                          dn_valid,
	input  wire logic                                     dn_ready,
	output logic [3*COORD_BITS+FRAC_BITS:0]               acc_x_out,
	output logic [3*COORD_BITS+FRAC_BITS:0]               acc_y_out,
	output logic [2*COORD_BITS:0]                         den_out,
	output sip_pkg::sip_flags_t                           flags_out,
	output logic [COORD_BITS-1:0]                         base_x_out,
	output logic [COORD_BITS-1:0]                         base_y_out
);
	import sip_pkg::*;

	localparam int DW = 2 * COORD_BITS + 1;
	localparam int QW = COORD_BITS + FRAC_BITS;
	localparam int AW = DW + QW;

	// The upper bits hold the partial remainder, the lower bits the dividend bits
	// still to come followed by the quotient bits found so far.
	function automatic logic [AW-1:0] div_step(input logic [AW-1:0] acc,
		input logic [DW-1:0] d);
		logic [DW:0] t;
		logic [DW:0] diff;
		t    = acc[AW-1:QW-1];
		diff = t - {1'b0, d};
		if (t >= {1'b0, d}) begin
			div_step = {diff[DW-1:0], acc[QW-2:0], 1'b1};
		end else begin
			div_step = {t[DW-1:0], acc[QW-2:0], 1'b0};
		end
	endfunction

	logic             v_q;
	logic [AW-1:0]    acc_x_q, acc_y_q;
	logic [DW-1:0]    den_q;
	sip_flags_t       flags_q;
	logic [COORD_BITS-1:0] base_x_q, base_y_q;

	assign up_ready = !v_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			acc_x_q  <= div_step(acc_x_in, den_in);
			acc_y_q  <= div_step(acc_y_in, den_in);
			den_q    <= den_in;
			flags_q  <= flags_in;
			base_x_q <= base_x_in;
			base_y_q <= base_y_in;
		end
	end

	assign dn_valid   = v_q;
	assign acc_x_out  = acc_x_q;
	assign acc_y_out  = acc_y_q;
	assign den_out    = den_q;
	assign flags_out  = flags_q;
	assign base_x_out = base_x_q;
	assign base_y_out = base_y_q;

endmodule

`default_nettype wire

// ===== src/segment_intersection_point_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tests two closed segments for an exact integer intersection and gives the crossing
// point in unsigned fixed point with FRAC_BITS fraction bits, or zeros and hit low when
// they do not cross; parallel and degenerate pairs never hit. One segment pair is taken
// every cycle while in_stall is low. The front stages form the cross products, the hit
// test and the numerator products, then a row of one-bit restoring divider cells, one per
// quotient bit, produces the interpolation offset, and a final register adds the start
// point. Every stage only waits when the stage after it holds a word that cannot
// move on.
module segment_intersection_point_top #(
	parameter int COORD_BITS = sip_pkg::SIP_COORD_BITS,
	parameter int FRAC_BITS  = sip_pkg::SIP_FRAC_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [COORD_BITS-1:0]           a_start_x,
	input  wire logic [COORD_BITS-1:0]           a_start_y,
	input  wire logic [COORD_BITS-1:0]           a_end_x,
	input  wire logic [COORD_BITS-1:0]           a_end_y,
	input  wire logic [COORD_BITS-1:0]           b_start_x,
	input  wire logic [COORD_BITS-1:0]           b_start_y,
	input  wire logic [COORD_BITS-1:0]           b_end_x,
	input  wire logic [COORD_BITS-1:0]           b_end_y,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 hit,
	output logic [COORD_BITS+FRAC_BITS-1:0]      cross_x,
	output logic [COORD_BITS+FRAC_BITS-1:0]      cross_y
);
	import sip_pkg::*;

	localparam int CW  = COORD_BITS;
	localparam int DW  = 2 * CW + 1;
	localparam int QW  = CW + FRAC_BITS;
	localparam int AW  = DW + QW;
	localparam int QLW = DW + CW;

	logic             f_valid;
	logic [QLW-1:0]   f_qx, f_qy;

	logic             c_valid  [QW+1];
	logic             c_ready  [QW+1];
	logic [AW-1:0]    c_acc_x  [QW+1];
	logic [AW-1:0]    c_acc_y  [QW+1];
	logic [DW-1:0]    c_den    [QW+1];
	sip_flags_t       c_flags  [QW+1];
	logic [CW-1:0]    c_base_x [QW+1];
	logic [CW-1:0]    c_base_y [QW+1];

	logic             o_ready;
	logic             out_valid_q;
	logic             hit_q;
	logic [QW-1:0]    cross_x_q, cross_y_q;
	logic [QW-1:0]    base_x, base_y, res_x, res_y;

	sip_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.p0x      (a_start_x),
		.p0y      (a_start_y),
		.p1x      (a_end_x),
		.p1y      (a_end_y),
		.p2x      (b_start_x),
		.p2y      (b_start_y),
		.p3x      (b_end_x),
		.p3y      (b_end_y),
		.dn_valid (f_valid),
		.dn_ready (c_ready[0]),
		.q_x      (f_qx),
		.q_y      (f_qy),
		.den      (c_den[0]),
		.flags    (c_flags[0]),
		.base_x   (c_base_x[0]),
		.base_y   (c_base_y[0])
	);

	assign c_valid[0] = f_valid;
	assign c_acc_x[0] = AW'(f_qx) << FRAC_BITS;
	assign c_acc_y[0] = AW'(f_qy) << FRAC_BITS;

	for (genvar i = 0; i < QW; i++) begin : g_cell
		sip_div_cell #(
			.COORD_BITS(COORD_BITS),
			.FRAC_BITS (FRAC_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.up_valid   (c_valid[i]),
			.up_ready   (c_ready[i]),
			.acc_x_in   (c_acc_x[i]),
			.acc_y_in   (c_acc_y[i]),
			.den_in     (c_den[i]),
			.flags_in   (c_flags[i]),
			.base_x_in  (c_base_x[i]),
			.base_y_in  (c_base_y[i]),
			.dn_valid   (c_valid[i+1]),
			.dn_ready   (c_ready[i+1]),
			.acc_x_out  (c_acc_x[i+1]),
			.acc_y_out  (c_acc_y[i+1]),
			.den_out    (c_den[i+1]),
			.flags_out  (c_flags[i+1]),
			.base_x_out (c_base_x[i+1]),
			.base_y_out (c_base_y[i+1])
		);
	end

	assign o_ready     = !out_valid_q || !out_stall;
	assign c_ready[QW] = o_ready;

	always_comb begin
		base_x = QW'(c_base_x[QW]) << FRAC_BITS;
		base_y = QW'(c_base_y[QW]) << FRAC_BITS;
		res_x  = c_flags[QW].neg_x ? base_x - c_acc_x[QW][QW-1:0]
			: base_x + c_acc_x[QW][QW-1:0];
		res_y  = c_flags[QW].neg_y ? base_y - c_acc_y[QW][QW-1:0]
			: base_y + c_acc_y[QW][QW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (o_ready) begin
			out_valid_q <= c_valid[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (o_ready) begin
			hit_q     <= c_flags[QW].hit;
			cross_x_q <= c_flags[QW].hit ? res_x : '0;
			cross_y_q <= c_flags[QW].hit ? res_y : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign cross_x   = cross_x_q;
	assign cross_y   = cross_y_q;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int CW = sip_pkg::SIP_COORD_BITS;
	localparam int FW = sip_pkg::SIP_FRAC_BITS;
	localparam int PW = CW + FW;
	localparam int CMAX = (1 << CW) - 1;
	localparam int RANDOM_PAIRS = 1500;
	localparam int PHASE_LEN = 150;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;

	typedef logic [CW-1:0] coord_t;

	typedef struct {
		coord_t a_start_x;
		coord_t a_start_y;
		coord_t a_end_x;
		coord_t a_end_y;
		coord_t b_start_x;
		coord_t b_start_y;
		coord_t b_end_x;
		coord_t b_end_y;
	} segment_pair_t;

	typedef struct {
		logic hit;
		logic [PW-1:0] cross_x;
		logic [PW-1:0] cross_y;
	} crossing_t;

	class crossing_board;
		crossing_t expected_crossings[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		task report(string msg);
			errors++;
			$display("ERROR at %0t: %s", $time, msg);
		endtask

		function logic [PW-1:0] axis_point(longint start, longint dir, longint num, longint den);
			longint mag;
			longint offset;
			longint point;
			mag = (dir < 0) ? -dir : dir;
			offset = ((num * mag) << FW) / den;
			point = (dir < 0) ? (start << FW) - offset : (start << FW) + offset;
			return point[PW-1:0];
		endfunction

		function crossing_t predict_crossing(segment_pair_t p);
			longint ax0, ay0, bx0, by0;
			longint dax, day, dbx, dby, ox, oy;
			longint den, num_b, num_a;
			crossing_t r;
			ax0 = longint'(p.a_start_x);
			ay0 = longint'(p.a_start_y);
			bx0 = longint'(p.b_start_x);
			by0 = longint'(p.b_start_y);
			dax = longint'(p.a_end_x) - ax0;
			day = longint'(p.a_end_y) - ay0;
			dbx = longint'(p.b_end_x) - bx0;
			dby = longint'(p.b_end_y) - by0;
			ox = ax0 - bx0;
			oy = ay0 - by0;
			den = dax * dby - dbx * day;
			num_b = dax * oy - day * ox;
			num_a = dbx * oy - dby * ox;
			if (den < 0) begin
				den = -den;
				num_b = -num_b;
				num_a = -num_a;
			end
			r.hit = 1'b0;
			r.cross_x = '0;
			r.cross_y = '0;
			if (den != 0 && num_b >= 0 && num_b <= den && num_a >= 0 && num_a <= den) begin
				r.hit = 1'b1;
				r.cross_x = axis_point(ax0, dax, num_a, den);
				r.cross_y = axis_point(ay0, day, num_a, den);
			end
			return r;
		endfunction

		function void note_pair(segment_pair_t p);
			expected_crossings.insert(expected_crossings.size(), predict_crossing(p));
		endfunction

		function int outstanding();
			return expected_crossings.size();
		endfunction

		task check_result(crossing_t got);
			crossing_t want;
			if (expected_crossings.size() == 0) begin
				report("result word arrived with nothing expected");
			end else begin
				want = expected_crossings.pop_front();
				if (got.hit !== want.hit)
					report($sformatf("hit: got %0d, expected %0d", got.hit, want.hit));
				if (got.cross_x !== want.cross_x)
					report($sformatf("cross_x: got %0d, expected %0d", got.cross_x,
						want.cross_x));
				if (got.cross_y !== want.cross_y)
					report($sformatf("cross_y: got %0d, expected %0d", got.cross_y,
						want.cross_y));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	coord_t a_start_x, a_start_y, a_end_x, a_end_y;
	coord_t b_start_x, b_start_y, b_end_x, b_end_y;
	logic out_valid;
	logic out_stall;
	logic hit;
	logic [PW-1:0] cross_x;
	logic [PW-1:0] cross_y;

	crossing_board board;
	bit tx_calm;
	bit rx_calm;
	bit hold_req;
	int cycle_count;

	segment_intersection_point_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.a_start_x(a_start_x),
		.a_start_y(a_start_y),
		.a_end_x(a_end_x),
		.a_end_y(a_end_y),
		.b_start_x(b_start_x),
		.b_start_y(b_start_y),
		.b_end_x(b_end_x),
		.b_end_y(b_end_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.cross_x(cross_x),
		.cross_y(cross_y)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic coord_t clamp(int v);
		if (v < 0)
			return '0;
		if (v > CMAX)
			return coord_t'(CMAX);
		return coord_t'(v);
	endfunction

	function automatic segment_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
			int bx0, int by0, int bx1, int by1);
		segment_pair_t p;
		p.a_start_x = clamp(ax0);
		p.a_start_y = clamp(ay0);
		p.a_end_x = clamp(ax1);
		p.a_end_y = clamp(ay1);
		p.b_start_x = clamp(bx0);
		p.b_start_y = clamp(by0);
		p.b_end_x = clamp(bx1);
		p.b_end_y = clamp(by1);
		return p;
	endfunction

	function automatic int rnd_coord();
		return $urandom_range(0, CMAX);
	endfunction

	function automatic segment_pair_t random_pair();
		int ax0, ay0, ax1, ay1, qx, qy, dx, dy, k;
		segment_pair_t p;
		ax0 = rnd_coord();
		ay0 = rnd_coord();
		ax1 = rnd_coord();
		ay1 = rnd_coord();
		qx = rnd_coord();
		qy = rnd_coord();
		case ($urandom_range(0, 9))
			0, 1: begin
				p = make_pair(ax0, ay0, ax1, ay1, qx, qy, rnd_coord(), rnd_coord());
			end
			2, 3, 4: begin
				// The second segment runs through the midpoint of the first.
				p = make_pair(ax0, ay0, ax1, ay1, qx, qy, ax0 + ax1 - qx, ay0 + ay1 - qy);
			end
			5: begin
				p = make_pair(ax0 % 16, ay0 % 16, ax1 % 16, ay1 % 16,
					qx % 16, qy % 16, $urandom_range(0, 15), $urandom_range(0, 15));
			end
			6: begin
				if ($urandom_range(0, 1))
					p = make_pair(ax0, ay0, ax1, ay1, ax1, ay1, qx, qy);
				else
					p = make_pair(ax0, ay0, ax1, ay1, qx, qy, ax0, ay0);
			end
			7, 8: begin
				dx = $urandom_range(0, 400) - 200;
				dy = $urandom_range(0, 400) - 200;
				ax0 = $urandom_range(450, CMAX - 450);
				ay0 = $urandom_range(450, CMAX - 450);
				k = $urandom_range(0, 4) - 2;
				if ($urandom_range(0, 1)) begin
					qx = ax0 + k * dx / 2;
					qy = ay0 + k * dy / 2;
				end else begin
					qx = ax0 + $urandom_range(0, 20) - 10;
					qy = ay0 + $urandom_range(0, 20) - 10;
				end
				p = make_pair(ax0, ay0, ax0 + dx, ay0 + dy, qx, qy, qx - k * dx, qy - k * dy);
			end
			default: begin
				// Axis-aligned pairs.
				p = make_pair(ax0, ay0, ax1, ay0, qx, ay0 - $urandom_range(0, 40),
					qx, ay0 + $urandom_range(0, 40));
			end
		endcase
		return p;
	endfunction

	task automatic send_pair(segment_pair_t p);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		a_start_x <= p.a_start_x;
		a_start_y <= p.a_start_y;
		a_end_x <= p.a_end_x;
		a_end_y <= p.a_end_y;
		b_start_x <= p.b_start_x;
		b_start_y <= p.b_start_y;
		b_end_x <= p.b_end_x;
		b_end_y <= p.b_end_y;
		do @(posedge clk); while (in_stall);
		board.note_pair(p);
	endtask

	task automatic wait_for_drain();
		while (board.outstanding() != 0)
			@(posedge clk);
	endtask

	initial begin
		int mode;
		board = new();
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		hold_req = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		out_stall <= 1'b0;
		a_start_x <= '0;
		a_start_y <= '0;
		a_end_x <= '0;
		a_end_y <= '0;
		b_start_x <= '0;
		b_start_y <= '0;
		b_end_x <= '0;
		b_end_y <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(make_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
		send_pair(make_pair(0, 0, CMAX, CMAX, 0, CMAX, CMAX, 0));
		send_pair(make_pair(CMAX, CMAX, 0, 0, 0, CMAX, CMAX, 0));
		send_pair(make_pair(CMAX, 0, 0, CMAX, CMAX, CMAX, 0, 0));
		send_pair(make_pair(0, 0, 100, 100, 100, 100, 200, 0));
		send_pair(make_pair(500, 500, 900, 100, 500, 500, 100, 100));
		send_pair(make_pair(0, 1000, 2000, 1000, 1000, 1000, 1000, 2000));
		send_pair(make_pair(0, 1000, 2000, 1000, 1000, 1001, 1000, 2000));
		send_pair(make_pair(0, 0, 1000, 1000, 0, 10, 1000, 1010));
		send_pair(make_pair(0, 0, 1000, 1000, 500, 500, 1500, 1500));
		send_pair(make_pair(300, 300, 300, 300, 0, 0, 600, 600));
		send_pair(make_pair(1024, 0, 1024, CMAX, 0, 1024, CMAX, 1024));
		send_pair(make_pair(0, 0, 3, 1, 0, 1, 3, 0));
		send_pair(make_pair(CMAX, 0, CMAX, CMAX, 0, CMAX, CMAX, CMAX));
		send_pair(make_pair(0, 0, CMAX, 1, 1000, 0, 1001, CMAX));
		send_pair(make_pair(0, 0, 10, 10, 100, 0, 90, 10));
		send_pair(make_pair(1365, 682, 682, 1365, 682, 682, 1365, 1365));
		send_pair(make_pair(CMAX, 0, 0, 0, 0, CMAX, 0, 0));
		send_pair(make_pair(1, 1, CMAX - 1, CMAX - 1, 1, CMAX - 1, CMAX - 1, 1));
		in_valid <= 1'b0;
		wait_for_drain();

		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			if (i % PHASE_LEN == 0) begin
				mode = $urandom_range(0, 3);
				tx_calm = (mode == 1 || mode == 3);
				rx_calm = (mode == 1 || mode == 2);
			end
			if (i == 500) begin
				// Sender stays quiet until the pipeline has fully emptied.
				in_valid <= 1'b0;
				wait_for_drain();
				@(posedge clk);
			end
			if (i == 800) begin
				hold_req = 1'b1;
				tx_calm = 1'b1;
			end
			send_pair(random_pair());
		end
		in_valid <= 1'b0;
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("PASS segment_intersection_point_top");
		else
			$display("FAIL segment_intersection_point_top");
		$finish;
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				gap = rx_calm ? 0 : $urandom_range(0, 9);
				if (gap > 0) begin
					out_stall <= 1'b1;
					repeat (gap) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		crossing_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.hit = hit;
			got.cross_x = cross_x;
			got.cross_y = cross_y;
			board.check_result(got);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (cycle_count == CYCLE_LIMIT) begin
				$display("FAIL segment_intersection_point_top");
				$finish;
			end
		end
	end

endmodule
